FILE: sv/nsc_pkg.sv
`timescale 1ns / 1ps

package nsc_pkg;

  // Fixed field widths of the request and result payloads
  localparam int VALUE_W       = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DEG_W         = 2;
  localparam int ITER_W        = 10;
  localparam int STAT_W        = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'b1;
  localparam logic [ITER_W-1:0]    MAX_ITER_RESET = 10'd100;

  // Root degrees
  localparam logic [DEG_W-1:0] DEG_SQUARE = 2'd2;
  localparam logic [DEG_W-1:0] DEG_CUBE   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_CONVERGED = 3'd0;
  localparam logic [STAT_W-1:0] STAT_LIMIT     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_DEG   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NEG_SQ    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ZERO_GUESS = 3'd4;
  localparam logic [STAT_W-1:0] STAT_EST_ZERO  = 3'd5;

  typedef struct packed {
    logic signed [VALUE_W-1:0] radicand;
    logic [DEG_W-1:0]          degree;
    logic signed [VALUE_W-1:0] start_guess;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] root;
    logic [VALUE_W-1:0]        last_change;
    logic [ITER_W-1:0]         iterations;
    logic [STAT_W-1:0]         status;
  } out_t;

endpackage

FILE: sv/nsc_div.sv
`timescale 1ns / 1ps

module nsc_div #(
  parameter int FRAC_BITS = nsc_pkg::FRAC_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  input  logic [nsc_pkg::VALUE_W+FRAC_BITS-1:0]        dividend,
  input  logic [nsc_pkg::VALUE_W-1:0]                  divisor,
  output logic                                         done,
  output logic [nsc_pkg::VALUE_W+FRAC_BITS-1:0]        quotient
);
  import nsc_pkg::*;

  localparam int DW    = VALUE_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [VALUE_W-1:0] rem_r;
  logic [VALUE_W-1:0] dvs_r;
  logic [DW-1:0]      quo_r;

  logic [VALUE_W:0]   trial;
  logic               fits;
  logic [VALUE_W:0]   diff;

  // Shift next dividend bit into the partial remainder and try the subtract
  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  // Control: count one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring long division, quotient shifts in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: sv/nsc_core.sv
`timescale 1ns / 1ps

module nsc_core #(
  parameter int FRAC_BITS = nsc_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  nsc_pkg::in_t                 item,
  input  logic [nsc_pkg::VALUE_W-1:0]  tolerance,
  input  logic [nsc_pkg::ITER_W-1:0]   iter_limit,
  input  logic                         res_take,
  output logic                         ready,
  output logic                         res_valid,
  output nsc_pkg::out_t                res
);
  import nsc_pkg::*;

  localparam int W    = VALUE_W;
  localparam int DW   = VALUE_W + FRAC_BITS;
  localparam int D3_W = 48;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DSET = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_DIV3 = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  localparam logic [W-1:0] VMAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN  = {1'b1, {(W-1){1'b0}}};

  // Reciprocal of three, exact for an 18-bit partial dividend
  localparam logic [17:0] THIRD_K = 18'd174763;
  localparam logic [1:0]  D3_LAST = 2'd2;

  function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [3:0]        state_r;
  logic [W-1:0]      a_r;
  logic              deg3_r;
  logic [W-1:0]      p_r;
  logic [W-1:0]      pnew_r;
  logic [W-1:0]      q_r;
  logic [2*W-1:0]    prod_r;
  logic              neg_r;
  logic              tneg_r;
  logic [W-1:0]      change_r;
  logic [ITER_W-1:0] iter_r;
  logic [STAT_W-1:0] status_r;
  logic [D3_W-1:0]   d3_sh_r;
  logic [1:0]        d3_rem_r;
  logic [1:0]        d3_cnt_r;

  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [W-1:0]  div_divisor;
  logic          div_done;
  logic [DW-1:0] div_quo;

  logic [W-1:0]      pm;
  logic [2*W-1:0]    sq_wide;
  logic [W-1:0]      sq_sat;
  logic [W-1:0]      dsig;
  logic [W-1:0]      dmag;
  logic              dneg;
  logic [DW-1:0]     lim;
  logic [DW-1:0]     qm;
  logic [W:0]        s_sum;
  logic [W+1:0]      t_sum;
  logic [W+1:0]      t_mag;
  logic [W:0]        dif;
  logic [W-1:0]      chg;
  logic [ITER_W-1:0] iter_nxt;
  logic [17:0]       d3_v;
  logic [35:0]       d3_prod;
  logic [15:0]       d3_digit;
  logic [17:0]       d3_left;
  logic [W-1:0]      d3_quo;

  nsc_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Arithmetic around the shared divider
  always_comb begin
    pm       = mag_f(p_r);
    sq_wide  = prod_r >> FRAC_BITS;
    sq_sat   = (|sq_wide[2*W-1:W-1]) ? VMAXP : sq_wide[W-1:0];
    dsig     = deg3_r ? sq_sat : p_r;
    dmag     = mag_f(dsig);
    dneg     = a_r[W-1] ^ dsig[W-1];
    lim      = {{(DW-W){1'b0}}, neg_r, {(W-1){~neg_r}}};
    qm       = (div_quo > lim) ? lim : div_quo;
    s_sum    = {p_r[W-1], p_r} + {q_r[W-1], q_r};
    t_sum    = {p_r[W-1], p_r, 1'b0} + {{2{q_r[W-1]}}, q_r};
    t_mag    = t_sum[W+1] ? (~t_sum + 1'b1) : t_sum;
    dif      = {pnew_r[W-1], pnew_r} - {p_r[W-1], p_r};
    chg      = dif[W] ? W'(~dif + 1'b1) : dif[W-1:0];
    iter_nxt = iter_r + 1'b1;
  end

  // Divide by three, 16 dividend bits per cycle, remainder carried between steps
  always_comb begin
    d3_v     = {d3_rem_r, d3_sh_r[D3_W-1:D3_W-16]};
    d3_prod  = {18'b0, d3_v} * {18'b0, THIRD_K};
    d3_digit = d3_prod[34:19];
    d3_left  = d3_v - ({1'b0, d3_digit, 1'b0} + {2'b0, d3_digit});
    d3_quo   = {d3_sh_r[15:0], d3_digit};
  end

  // Launch the divider for the Newton quotient in S_DSET
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {mag_f(a_r), {FRAC_BITS{1'b0}}};
    div_divisor  = dmag;
    case (state_r)
      S_DSET: begin
        div_start = (dmag != '0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Sequence one Newton iteration after another
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            a_r      <= item.radicand;
            deg3_r   <= (item.degree == DEG_CUBE);
            p_r      <= item.start_guess;
            iter_r   <= '0;
            change_r <= '0;
            if (item.degree != DEG_SQUARE && item.degree != DEG_CUBE) begin
              status_r <= STAT_BAD_DEG;
              p_r      <= '0;
              state_r  <= S_DONE;
            end else if (item.degree == DEG_SQUARE && item.radicand[W-1]) begin
              status_r <= STAT_NEG_SQ;
              p_r      <= '0;
              state_r  <= S_DONE;
            end else if (item.start_guess == '0) begin
              status_r <= STAT_ZERO_GUESS;
              state_r  <= S_DONE;
            end else begin
              state_r <= (item.degree == DEG_CUBE) ? S_MUL : S_DSET;
            end
          end
        end
        S_MUL: begin
          prod_r  <= pm * pm;
          state_r <= S_DSET;
        end
        S_DSET: begin
          neg_r <= dneg;
          // Zero divisor saturates toward the radicand's sign
          if (dmag == '0) begin
            q_r     <= (a_r == '0) ? '0 : (dneg ? VMIN : VMAXP);
            state_r <= S_UPD;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            q_r     <= neg_r ? W'(~qm + 1'b1) : qm[W-1:0];
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (deg3_r) begin
            tneg_r   <= t_sum[W+1];
            d3_sh_r  <= {{(D3_W-W-2){1'b0}}, t_mag};
            d3_rem_r <= '0;
            d3_cnt_r <= '0;
            state_r  <= S_DIV3;
          end else begin
            pnew_r  <= s_sum[W:1];
            state_r <= S_CHK;
          end
        end
        S_DIV3: begin
          d3_sh_r  <= {d3_sh_r[D3_W-17:0], d3_digit};
          d3_rem_r <= d3_left[1:0];
          d3_cnt_r <= d3_cnt_r + 1'b1;
          if (d3_cnt_r == D3_LAST) begin
            pnew_r  <= tneg_r ? (~d3_quo + 1'b1) : d3_quo;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          p_r      <= pnew_r;
          change_r <= chg;
          iter_r   <= iter_nxt;
          if (chg <= tolerance) begin
            status_r <= STAT_CONVERGED;
            state_r  <= S_DONE;
          end else if (pnew_r == '0) begin
            status_r <= STAT_EST_ZERO;
            state_r  <= S_DONE;
          end else if (iter_nxt >= iter_limit) begin
            status_r <= STAT_LIMIT;
            state_r  <= S_DONE;
          end else begin
            state_r <= deg3_r ? S_MUL : S_DSET;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Present the finished result
  always_comb begin
    ready           = (state_r == S_IDLE);
    res_valid       = (state_r == S_DONE);
    res.root        = p_r;
    res.last_change = change_r;
    res.iterations  = iter_r;
    res.status      = status_r;
  end

  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_DIV))
    else $error("divider launched without waiting for it");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (status_r == STAT_BAD_DEG || status_r == STAT_NEG_SQ ||
      status_r == STAT_ZERO_GUESS)) |-> (p_r == '0 && iter_r == '0 && change_r == '0))
    else $error("rejected request carries nonzero result");

  a_iter_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (status_r == STAT_CONVERGED || status_r == STAT_LIMIT ||
      status_r == STAT_EST_ZERO)) |-> (iter_r != '0))
    else $error("iterative result without any iteration");

endmodule

FILE: sv/newton_square_cube_root.sv
`timescale 1ns / 1ps

// Newton-Raphson square and cube root, signed fixed point (Q16.16 by default).
// Request channel in_*: radicand, degree (2 or 3) and a nonzero start guess,
// taken when in_valid is high and in_stall is low. Result channel out_*: root,
// last change, iteration count and status, held while out_stall is high.
// Configuration port cfg_*: index 0 tolerance, index 1 iteration limit,
// written while cfg_we is high; write only while no request is in flight.
// One request is worked on at a time; in_stall stays high until its result
// has moved into the output register, which frees the core for the next one.
// Each quotient with a nonzero divisor goes through one restoring divider that
// yields one bit per cycle; a cube-root iteration (square, quotient, a third by
// a three-step reciprocal multiply) skips the divider when the square is zero.
// A rejected request goes straight to the done state. out_valid rises as the
// result is loaded into the output register; with that register free the core
// returns to idle as it is loaded, so the next request can then be taken.
// Reset clears the sequencer and output valid and sets tolerance 0 and the
// iteration limit 100. A stalled receiver holds the result in the output
// register; the core then waits in its done state with the next result.
module newton_square_cube_root #(
  parameter int FRAC_BITS = nsc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nsc_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output nsc_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [nsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nsc_pkg::*;

  logic [VALUE_W-1:0] tolerance_r;
  logic [ITER_W-1:0]  iter_limit_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic core_ready;
  logic core_valid;
  out_t core_res;
  logic res_take;

  // Capture configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r  <= '0;
      iter_limit_r <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOLERANCE: tolerance_r  <= cfg_wdata[VALUE_W-1:0];
        REG_MAX_ITER:  iter_limit_r <= cfg_wdata[ITER_W-1:0];
        default: begin
          iter_limit_r <= iter_limit_r;
        end
      endcase
    end
  end

  nsc_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_valid && core_ready),
    .item       (in_data),
    .tolerance  (tolerance_r),
    .iter_limit (iter_limit_r),
    .res_take   (res_take),
    .ready      (core_ready),
    .res_valid  (core_valid),
    .res        (core_res)
  );

  assign in_stall = !core_ready;
  assign res_take = !out_valid_r || !out_stall;

  // Output register: load a finished result, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (core_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && res_take) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: test/nsc_root_checker.sv
`timescale 1ns / 1ps

module nsc_root_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  nsc_pkg::in_t                   in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  nsc_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [nsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);
  import nsc_pkg::*;

  localparam int     FRAC    = FRAC_BITS_DEF;
  localparam longint POS_MAX = (64'sd1 <<< (VALUE_W - 1)) - 1;
  localparam longint NEG_MAG = 64'sd1 <<< (VALUE_W - 1);

  logic [VALUE_W-1:0] tolerance_q;
  logic [ITER_W-1:0]  iter_limit_q;
  out_t               expected_roots[$];
  int                 errors = 0;
  int                 seen = 0;

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Signed fixed-point quotient, truncated toward zero, saturated to the value range
  function automatic longint sat_quotient(longint num, longint den);
    longint n, d, q, r, lim;
    bit     neg;
    neg = (num < 0) != (den < 0);
    lim = neg ? NEG_MAG : POS_MAX;
    n = abs64(num);
    d = abs64(den);
    if (d == 0) begin
      q = (n != 0) ? lim : 0;
    end else begin
      q = n / d;
      r = n % d;
      if (q > (lim >>> FRAC)) begin
        q = lim;
      end else begin
        q = (q <<< FRAC) | ((r <<< FRAC) / d);
        if (q > lim) q = lim;
      end
    end
    return neg ? -q : q;
  endfunction

  // Fixed-point square of the magnitude, clipped to the largest positive value
  function automatic longint sat_square(longint v);
    longint sq;
    sq = (abs64(v) * abs64(v)) >>> FRAC;
    return (sq > POS_MAX) ? POS_MAX : sq;
  endfunction

  // Run the Newton iterations for one request under the current limits
  function automatic out_t newton_root(in_t req);
    out_t        res;
    longint      a, p, prev, sum, delta;
    int unsigned n_iter;
    bit          running;
    res = '0;
    a = $signed(req.radicand);
    p = $signed(req.start_guess);
    if (req.degree != DEG_SQUARE && req.degree != DEG_CUBE) begin
      res.status = STAT_BAD_DEG;
    end else if (req.degree == DEG_SQUARE && a < 0) begin
      res.status = STAT_NEG_SQ;
    end else if (p == 0) begin
      res.status = STAT_ZERO_GUESS;
    end else begin
      n_iter  = 0;
      delta   = 0;
      running = 1'b1;
      while (running) begin
        prev = p;
        if (req.degree == DEG_SQUARE) begin
          sum = prev + sat_quotient(a, prev);
          p   = sum >>> 1;
        end else begin
          sum = 2 * prev + sat_quotient(a, sat_square(prev));
          p   = sum / 3;
        end
        delta  = abs64(p - prev);
        n_iter = n_iter + 1;
        running = 1'b0;
        // converged beats zero estimate, which beats the iteration limit
        if (delta <= longint'(tolerance_q)) res.status = STAT_CONVERGED;
        else if (p == 0) res.status = STAT_EST_ZERO;
        else if (n_iter >= iter_limit_q) res.status = STAT_LIMIT;
        else running = 1'b1;
      end
      res.root        = p[VALUE_W-1:0];
      res.last_change = delta[VALUE_W-1:0];
      res.iterations  = n_iter[ITER_W-1:0];
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // Track the limits, predict on each request, compare on each result
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      tolerance_q  = '0;
      iter_limit_q = MAX_ITER_RESET;
      expected_roots.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TOLERANCE) tolerance_q = cfg_wdata;
        else if (cfg_index == REG_MAX_ITER) iter_limit_q = cfg_wdata[ITER_W-1:0];
      end
      if (in_valid && !in_stall) expected_roots.push_back(newton_root(in_data));
      if (out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          $error("result with no request pending: root %h status %0d",
                 out_data.root, out_data.status);
          errors++;
        end else begin
          want = expected_roots.pop_front();
          check_field("root", want.root, out_data.root);
          check_field("last_change", want.last_change, out_data.last_change);
          check_field("iterations", VALUE_W'(want.iterations), VALUE_W'(out_data.iterations));
          check_field("status", VALUE_W'(want.status), VALUE_W'(out_data.status));
          seen++;
        end
      end
    end
    pending    <= expected_roots.size();
    fail_count <= errors;
    checked    <= seen;
  end

endmodule

FILE: test/tb_newton_square_cube_root.sv
`timescale 1ns / 1ps

module tb_newton_square_cube_root;
  import nsc_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 7;
  localparam int MAX_CYCLES     = 3_000_000;
  localparam int LONG_HOLD      = 4000;
  localparam int RAND_PHASES    = 4;
  localparam int RAND_PER_PHASE = 25;
  localparam int SETTLE_CYCLES  = 300;

  // Degrees the block rejects
  localparam logic [DEG_W-1:0] DEG_NONE   = 2'd0;
  localparam logic [DEG_W-1:0] DEG_LINEAR = 2'd1;

  localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic [VALUE_W-1:0]        TOL_ALL = 32'hffff_ffff;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic idle_on;
  logic hold_go;
  logic long_hold;
  logic drain_pause;
  int   cycles = 0;
  int   fail_count;
  int   pending;
  int   checked;
  int   n_sent = 0;
  int   n_settings = 1;

  always #CLK_HALF clk = ~clk;

  assign out_stall = drain_pause | long_hold;

  newton_square_cube_root u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nsc_root_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results pending", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Hold off the result side for a random number of cycles after each result while idle_on is set
  initial begin : drain_ctl
    int left;
    left = 0;
    drain_pause <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        left = idle_on ? $urandom_range(0, 14) : 0;
        if (left > 0) drain_pause <= 1'b1;
      end else if (left > 0) begin
        left--;
        if (left == 0) drain_pause <= 1'b0;
      end
    end
  end

  // Block the result side for one long stretch so the block backs up
  initial begin : long_hold_ctl
    long_hold <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold <= 1'b0;
  end

  function automatic in_t make_req(logic signed [VALUE_W-1:0] a, logic [DEG_W-1:0] deg,
                                   logic signed [VALUE_W-1:0] guess);
    in_t r;
    r.radicand    = a;
    r.degree      = deg;
    r.start_guess = guess;
    return r;
  endfunction

  // Mostly well-formed requests with spread magnitudes, some rejects and raw noise
  function automatic in_t rand_req();
    in_t         r;
    int unsigned pick;
    pick          = $urandom_range(0, 9);
    r.degree      = $urandom_range(0, 1) ? DEG_CUBE : DEG_SQUARE;
    r.radicand    = $urandom >> $urandom_range(1, 31);
    r.start_guess = ($urandom >> $urandom_range(1, 31)) | 32'd1;
    if (r.degree == DEG_CUBE && $urandom_range(0, 1)) r.radicand = -r.radicand;
    if ($urandom_range(0, 4) == 0) r.start_guess = -r.start_guess;
    case (pick)
      0: begin
        r.degree      = DEG_W'($urandom_range(0, 3));
        r.radicand    = $urandom;
        r.start_guess = $urandom;
      end
      1: r.start_guess = '0;
      2: if (r.degree == DEG_SQUARE) r.radicand = -r.radicand - 1;
      default: ;
    endcase
    return r;
  endfunction

  // Offer one request, after a random gap while idle_on is set, and hold it until taken
  task automatic send_req(in_t req);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write both limits back to back on an idle block
  task automatic start_phase(logic [VALUE_W-1:0] tol, logic [ITER_W-1:0] lim, logic idle);
    idle_on   <= idle;
    cfg_we    <= 1'b1;
    cfg_index <= REG_TOLERANCE;
    cfg_wdata <= tol;
    @(posedge clk);
    cfg_index <= REG_MAX_ITER;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    int               ph;
    int               k;
    logic [VALUE_W-1:0] tol;
    logic [ITER_W-1:0]  lim;
    logic             idle;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_TOLERANCE;
    cfg_wdata <= '0;
    idle_on   <= 1'b0;
    hold_go   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits: zero tolerance, 100 iterations
    send_req(make_req(V_MAX, DEG_NONE, Q_ONE));          // rejected degree
    send_req(make_req(V_MIN, DEG_LINEAR, V_MIN));
    send_req(make_req(V_MIN, DEG_NONE, '0));              // degree checked before guess
    send_req(make_req(-32'sd1, DEG_SQUARE, Q_ONE));       // negative square radicand
    send_req(make_req(V_MIN, DEG_SQUARE, '0));            // radicand checked before guess
    send_req(make_req(4 * Q_ONE, DEG_SQUARE, '0));        // zero guess
    send_req(make_req(-8 * Q_ONE, DEG_CUBE, '0));
    send_req(make_req(4 * Q_ONE, DEG_SQUARE, Q_ONE));
    send_req(make_req(V_MAX, DEG_SQUARE, V_MAX));
    send_req(make_req('0, DEG_SQUARE, 32'sd1));           // estimate drops to zero
    send_req(make_req('0, DEG_SQUARE, V_MAX));
    send_req(make_req(V_MIN, DEG_CUBE, V_MIN));
    send_req(make_req(V_MAX, DEG_CUBE, 32'sd1));          // square of guess truncates to zero
    send_req(make_req('0, DEG_CUBE, -32'sd1));
    send_req(make_req(27 * Q_ONE, DEG_CUBE, 3 * Q_ONE));  // exact root, zero change
    send_req(make_req(V_MAX, DEG_SQUARE, -32'sd1));       // quotient saturates negative
    send_req(make_req(-27 * Q_ONE, DEG_CUBE, V_MAX));
    wait_drained();

    // Widest tolerance and highest limit: one step each
    start_phase(TOL_ALL, {ITER_W{1'b1}}, 1'b1);
    send_req(make_req(V_MAX, DEG_SQUARE, V_MAX));
    send_req(make_req(V_MAX, DEG_SQUARE, V_MIN));
    send_req(make_req(V_MIN, DEG_CUBE, V_MAX));
    send_req(make_req(V_MAX, DEG_CUBE, V_MIN));
    wait_drained();

    // Limit of zero runs one iteration
    start_phase('0, '0, 1'b0);
    send_req(make_req(9 * Q_ONE, DEG_SQUARE, Q_ONE));
    send_req(make_req(Q_ONE, DEG_CUBE, Q_ONE));
    wait_drained();

    start_phase('0, 10'd1, 1'b1);
    send_req(make_req(2 * Q_ONE, DEG_SQUARE, Q_ONE));
    send_req(make_req(-8 * Q_ONE, DEG_CUBE, -2 * Q_ONE));
    wait_drained();

    // Random phases with a fresh pair of limits each
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          tol  = $urandom_range(0, 16);
          lim  = ITER_W'($urandom_range(4, 10));
          idle = 1'b1;
        end
        1: begin
          tol  = $urandom_range(16, 1024);
          lim  = ITER_W'($urandom_range(10, 30));
          idle = 1'b0;
        end
        2: begin
          tol  = '0;
          lim  = ITER_W'($urandom_range(1, 30));
          idle = 1'b1;
        end
        default: begin
          tol  = $urandom >> $urandom_range(0, 31);
          lim  = ITER_W'($urandom_range(1, 30));
          idle = 1'b1;
        end
      endcase
      start_phase(tol, lim, idle);
      if (ph == 0) hold_go <= 1'b1;
      for (k = 0; k < RAND_PER_PHASE; k++) send_req(rand_req());
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d requests under %0d limit settings,",
             checked, n_sent, n_settings);
    $display("covering rejects, saturation, zero estimates, a long result hold-off and idling.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
